FILE: hdl/mexp_pkg.sv
// ----------------------------------------------------------------------------
// Modular exponentiation package
// Shared constants, sequencer codes and the beat tag that travels the cell row.
// ----------------------------------------------------------------------------
package mexp_pkg;

  localparam int BASE_W = 32;
  localparam int NCELLS = BASE_W;

  localparam int ST_W = 3;
  localparam logic [ST_W-1:0] ST_IDLE = 3'd0;
  localparam logic [ST_W-1:0] ST_STEP = 3'd1;
  localparam logic [ST_W-1:0] ST_SQR  = 3'd2;
  localparam logic [ST_W-1:0] ST_WAIT = 3'd3;

  typedef struct packed {
    logic vld;
    logic sqr;
  } mexp_tag_t;

endpackage

FILE: hdl/mexp_cell.sv
// ----------------------------------------------------------------------------
// Modular multiplier cell
// One step of MSB-first interleaved modular multiplication: r = 2r + bit*a mod m.
// ----------------------------------------------------------------------------
module mexp_cell #(
  parameter int MW  = 31,
  parameter int BIT = 0
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  mexp_pkg::mexp_tag_t  tag_i,
  input  logic [MW-1:0]        r_i,
  input  logic [MW-1:0]        a_i,
  input  logic [mexp_pkg::BASE_W-1:0] b_i,
  input  logic [MW-1:0]        m_i,
  output mexp_pkg::mexp_tag_t  tag_o,
  output logic [MW-1:0]        r_o,
  output logic [MW-1:0]        a_o,
  output logic [mexp_pkg::BASE_W-1:0] b_o
);
  import mexp_pkg::*;

  logic [MW:0]   dbl;
  logic [MW:0]   dbl_red;
  logic [MW:0]   sum;
  logic [MW:0]   diff;
  logic [MW:0]   m_ext;
  logic [MW-1:0] r_nxt;
  mexp_tag_t     tag_r;
  logic [MW-1:0] r_r;
  logic [MW-1:0] a_r;
  logic [BASE_W-1:0] b_r;

  always_comb begin
    m_ext   = {1'b0, m_i};
    dbl     = {r_i, 1'b0};
    dbl_red = (dbl >= m_ext) ? dbl - m_ext : dbl;
    sum     = {1'b0, dbl_red[MW-1:0]} + (b_i[BIT] ? {1'b0, a_i} : '0);
    diff    = sum - m_ext;
    r_nxt   = (sum >= m_ext) ? diff[MW-1:0] : sum[MW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r <= '0;
    end else begin
      tag_r <= tag_i;
    end
    r_r <= r_nxt;
    a_r <= a_i;
    b_r <= b_i;
  end

  assign tag_o = tag_r;
  assign r_o   = r_r;
  assign a_o   = a_r;
  assign b_o   = b_r;

endmodule

FILE: hdl/modular_exponentiation.sv
// ----------------------------------------------------------------------------
// Modular exponentiation
// Right-to-left square-and-multiply over a row of modular multiplier cells.
//
//   Channel  Handshake              Payload
//   input    start, busy            in_base_value, in_exponent
//   result   out_valid (strobe)     out_power_result
//   config   cfg_valid, cfg_ready   cfg_data (modulus)
//
// The base is first reduced through the cell row. Each exponent bit up to the
// highest set one then sends a squaring, after a multiply into the accumulator
// when the bit is set; the result beat is registered once the exponent is
// spent. A modulus of 0 or 1 skips the row. Reset is synchronous and returns
// the block to idle with the modulus at its maximum. The receiver cannot stall.
// ----------------------------------------------------------------------------
module modular_exponentiation #(
  parameter int MOD_WIDTH = 31,
  parameter int EXP_WIDTH = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [mexp_pkg::BASE_W-1:0]   in_base_value,
  input  logic [EXP_WIDTH-1:0]          in_exponent,
  output logic                          out_valid,
  output logic [MOD_WIDTH-1:0]          out_power_result,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [MOD_WIDTH-1:0]          cfg_data
);
  import mexp_pkg::*;

  localparam int MW = MOD_WIDTH;

  logic [ST_W-1:0]      state_r, state_nxt;
  logic [MW-1:0]        mod_r;
  logic [EXP_WIDTH-1:0] exp_r, exp_nxt;
  logic [MW-1:0]        acc_r, acc_nxt;
  logic [MW-1:0]        base_r, base_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [MW-1:0]        out_res_r, out_res_nxt;

  mexp_tag_t            iss_tag;
  logic [MW-1:0]        iss_a;
  logic [BASE_W-1:0]    iss_b;

  mexp_tag_t            tag_c [NCELLS+1];
  logic [MW-1:0]        r_c   [NCELLS+1];
  logic [MW-1:0]        a_c   [NCELLS+1];
  logic [BASE_W-1:0]    b_c   [NCELLS+1];

  assign tag_c[0] = iss_tag;
  assign r_c[0]   = '0;
  assign a_c[0]   = iss_a;
  assign b_c[0]   = iss_b;

  for (genvar k = 0; k < NCELLS; k++) begin : g_cell
    mexp_cell #(.MW(MW), .BIT(BASE_W - 1 - k)) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .tag_i (tag_c[k]),
      .r_i   (r_c[k]),
      .a_i   (a_c[k]),
      .b_i   (b_c[k]),
      .m_i   (mod_r),
      .tag_o (tag_c[k+1]),
      .r_o   (r_c[k+1]),
      .a_o   (a_c[k+1]),
      .b_o   (b_c[k+1])
    );
  end

  always_comb begin
    state_nxt     = state_r;
    exp_nxt       = exp_r;
    acc_nxt       = acc_r;
    base_nxt      = base_r;
    out_valid_nxt = 1'b0;
    out_res_nxt   = out_res_r;
    iss_tag       = '0;
    iss_a         = base_r;
    iss_b         = BASE_W'(base_r);
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          exp_nxt = in_exponent;
          acc_nxt = MW'(1);
          if (mod_r <= MW'(1)) begin
            out_valid_nxt = 1'b1;
            out_res_nxt   = (in_exponent == '0) ? MW'(1) : '0;
          end else begin
            iss_tag   = '{vld: 1'b1, sqr: 1'b1};
            iss_a     = MW'(1);
            iss_b     = in_base_value;
            state_nxt = ST_WAIT;
          end
        end
      end
      ST_STEP: begin
        if (exp_r == '0) begin
          out_valid_nxt = 1'b1;
          out_res_nxt   = acc_r;
          state_nxt     = ST_IDLE;
        end else if (exp_r[0]) begin
          iss_tag   = '{vld: 1'b1, sqr: 1'b0};
          iss_a     = acc_r;
          state_nxt = ST_SQR;
        end else begin
          iss_tag   = '{vld: 1'b1, sqr: 1'b1};
          exp_nxt   = exp_r >> 1;
          state_nxt = ST_WAIT;
        end
      end
      ST_SQR: begin
        iss_tag   = '{vld: 1'b1, sqr: 1'b1};
        exp_nxt   = exp_r >> 1;
        state_nxt = ST_WAIT;
      end
      ST_WAIT: begin
        if (tag_c[NCELLS].vld) begin
          if (tag_c[NCELLS].sqr) begin
            base_nxt  = r_c[NCELLS];
            state_nxt = ST_STEP;
          end else begin
            acc_nxt = r_c[NCELLS];
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      mod_r       <= '1;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        mod_r <= cfg_data;
      end
    end
    exp_r     <= exp_nxt;
    acc_r     <= acc_nxt;
    base_r    <= base_nxt;
    out_res_r <= out_res_nxt;
  end

  assign busy             = (state_r != ST_IDLE);
  assign cfg_ready        = (state_r == ST_IDLE) && !start;
  assign out_valid        = out_valid_r;
  assign out_power_result = out_res_r;

endmodule

FILE: hdl/mexp_checker.sv
// ----------------------------------------------------------------------------
// Modular exponentiation checker
// Port-level assertions on the command and config handshakes and the strobe.
// ----------------------------------------------------------------------------
module mexp_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid,
  input logic cfg_valid,
  input logic cfg_ready
);

  a_start_acts: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy || out_valid)
    else $error("Accepted command neither started work nor answered.");

  a_done_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("Work ended without a result beat.");

  a_idle_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("Result beat while still busy.");

  a_busy_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(start))
    else $error("Busy rose without a command.");

  a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid && cfg_ready |-> !busy && !start)
    else $error("Configuration accepted while work was pending.");

endmodule

bind modular_exponentiation mexp_checker u_mexp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .cfg_valid (cfg_valid),
  .cfg_ready (cfg_ready)
);

FILE: dv/tb_modular_exponentiation.sv
// ----------------------------------------------------------------------------
// Modular exponentiation testbench
// Drives base and exponent beats under a series of moduli, including the
// degenerate moduli 0 and 1 and the maximum. Each accepted beat is predicted
// by square-and-multiply and checked against the strobed result.
// ----------------------------------------------------------------------------
module tb_modular_exponentiation;

  localparam int MOD_WIDTH = 31;
  localparam int EXP_WIDTH = 64;
  localparam int STALL_LIMIT = 20000;

  typedef struct {
    logic [mexp_pkg::BASE_W-1:0] base_value;
    logic [EXP_WIDTH-1:0]        exponent;
  } pow_req_t;

  logic                        clk;
  logic                        rst_n;
  logic                        start;
  logic                        busy;
  logic [mexp_pkg::BASE_W-1:0] in_base_value;
  logic [EXP_WIDTH-1:0]        in_exponent;
  logic                        out_valid;
  logic [MOD_WIDTH-1:0]        out_power_result;
  logic                        cfg_valid;
  logic                        cfg_ready;
  logic [MOD_WIDTH-1:0]        cfg_data;

  pow_req_t             req_q[$];
  logic [MOD_WIDTH-1:0] power_q[$];
  logic [MOD_WIDTH-1:0] cur_modulus;
  logic                 took;
  logic                 moved;
  int                   gap_left;
  int                   burst_left;
  int                   stall_cnt;
  int                   fail_cnt;
  int                   items_sent;
  int                   results_seen;
  int                   moduli_used;

  modular_exponentiation #(
    .MOD_WIDTH(MOD_WIDTH),
    .EXP_WIDTH(EXP_WIDTH)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_base_value(in_base_value),
    .in_exponent(in_exponent),
    .out_valid(out_valid),
    .out_power_result(out_power_result),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [MOD_WIDTH-1:0] pow_mod(logic [mexp_pkg::BASE_W-1:0] b_in,
                                                    logic [EXP_WIDTH-1:0] e_in,
                                                    logic [MOD_WIDTH-1:0] m_in);
    longint unsigned m;
    longint unsigned b;
    longint unsigned acc;
    logic [EXP_WIDTH-1:0] e;
    m = m_in;
    b = (m == 0) ? 0 : b_in % m;
    e = e_in;
    acc = 1;
    for (int i = 0; i < EXP_WIDTH; i++) begin
      if (e[i]) acc = (m == 0) ? 0 : (acc * b) % m;
      b = (m == 0) ? 0 : (b * b) % m;
    end
    return acc[MOD_WIDTH-1:0];
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      cur_modulus <= '1;
      took <= 1'b0;
      stall_cnt <= 0;
      fail_cnt <= 0;
      items_sent <= 0;
      results_seen <= 0;
    end else begin
      moved = 1'b0;
      took <= start && !busy;
      if (start && !busy) begin
        power_q.push_back(pow_mod(in_base_value, in_exponent, cur_modulus));
        void'(req_q.pop_front());
        items_sent <= items_sent + 1;
        moved = 1'b1;
      end
      if (cfg_valid && cfg_ready) begin
        cur_modulus <= cfg_data;
        moved = 1'b1;
      end
      if (out_valid) begin
        moved = 1'b1;
        results_seen <= results_seen + 1;
        if (power_q.size() == 0) begin
          $error("unexpected result power_result=%0d", out_power_result);
          fail_cnt <= fail_cnt + 1;
        end else begin
          if (out_power_result !== power_q[0]) begin
            $error("power_result expected %0d actual %0d", power_q[0], out_power_result);
            fail_cnt <= fail_cnt + 1;
          end
          void'(power_q.pop_front());
        end
      end
      if (moved) begin
        stall_cnt <= 0;
      end else begin
        stall_cnt <= stall_cnt + 1;
      end
      if (stall_cnt >= STALL_LIMIT) begin
        $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
        $display("tb_modular_exponentiation: FAIL");
        $finish;
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      in_base_value <= '0;
      in_exponent <= '0;
      gap_left <= 0;
      burst_left <= 0;
    end else if (!(start && !took)) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        start <= 1'b0;
      end else if (req_q.size() > 0) begin
        start <= 1'b1;
        in_base_value <= req_q[0].base_value;
        in_exponent <= req_q[0].exponent;
        if (burst_left > 0) begin
          burst_left <= burst_left - 1;
        end else begin
          burst_left <= $urandom_range(0, 8);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  task automatic add_req(logic [mexp_pkg::BASE_W-1:0] b, logic [EXP_WIDTH-1:0] e);
    pow_req_t r;
    r.base_value = b;
    r.exponent = e;
    req_q.push_back(r);
  endtask

  task automatic add_random_reqs(int n);
    logic [mexp_pkg::BASE_W-1:0] b;
    logic [EXP_WIDTH-1:0] e;
    int sel;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(0, 9);
      b = (sel == 0) ? '1 : (sel == 1) ? '0 : $urandom;
      e = {$urandom, $urandom};
      sel = $urandom_range(0, 99);
      if (sel < 80) e = e & ((64'd1 << $urandom_range(1, 12)) - 1);
      else if (sel < 95) e = e & ((64'd1 << $urandom_range(13, 32)) - 1);
      add_req(b, e);
    end
  endtask

  task automatic drain_queue();
    while (req_q.size() > 0 || start || power_q.size() > 0) @(posedge clk);
    repeat (5) @(posedge clk);
  endtask

  task automatic write_modulus(logic [MOD_WIDTH-1:0] m);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= m;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    moduli_used++;
  endtask

  initial begin
    logic [MOD_WIDTH-1:0] moduli[10];
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    moduli_used = 1;
    moduli = '{31'd1, 31'd0, 31'd2, 31'd3, 31'd65537, 31'd1000003, 31'h7FFF_FFFF,
               31'h4000_0000, MOD_WIDTH'($urandom), MOD_WIDTH'($urandom)};
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    add_req('0, '0);
    add_req('1, '0);
    add_req('0, 64'd1);
    add_req('1, 64'd1);
    add_req('1, '1);
    add_req(32'h8000_0000, 64'h8000_0000_0000_0000);
    add_req(32'h7FFF_FFFF, 64'd5);
    add_req(32'h7FFF_FFFE, 64'd2);
    add_req(32'd2, 64'd30);
    add_req(32'd2, 64'd31);
    add_req($urandom, {$urandom, $urandom});
    add_random_reqs(170);
    drain_queue();

    foreach (moduli[k]) begin
      write_modulus(moduli[k]);
      add_req('1, '0);
      add_req('1, '1);
      add_req({1'b0, moduli[k]}, 64'd3);
      add_random_reqs(160);
      drain_queue();
    end

    repeat (50) @(posedge clk);
    $display("covered %0d items and %0d results over %0d moduli", items_sent,
             results_seen, moduli_used);
    if (fail_cnt == 0 && power_q.size() == 0) begin
      $display("tb_modular_exponentiation: PASS");
    end else begin
      $display("tb_modular_exponentiation: FAIL");
    end
    $finish;
  end

endmodule

FILE: modular_exponentiation.f
hdl/mexp_pkg.sv
hdl/mexp_cell.sv
hdl/modular_exponentiation.sv
hdl/mexp_checker.sv
dv/tb_modular_exponentiation.sv
